[src/gce_pkg.sv]
// Shared constants, register codes and types for the glyph color expander.
`default_nettype none

package gce_pkg;

  localparam int ADDR_BITS       = 24;
  localparam int MAX_GLYPH_BYTES = 4;

  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int DIM_W      = 6;
  localparam int BPR_W      = 3;
  localparam int STRIDE_W   = 13;
  localparam int FBASE_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PROD_W     = COORD_W + STRIDE_W;
  localparam int BIR_W      = (MAX_GLYPH_BYTES > 1) ? $clog2(MAX_GLYPH_BYTES) : 1;
  localparam int BPR_INT_W  = 4;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = 3;
  localparam int COLS_W     = DIM_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR      = 3'd0,
    REG_CLEAR_COLOR   = 3'd1,
    REG_GLYPH_WIDTH   = 3'd2,
    REG_GLYPH_HEIGHT  = 3'd3,
    REG_BYTES_PER_ROW = 3'd4,
    REG_LINE_STRIDE   = 3'd5,
    REG_FRAME_BASE    = 3'd6
  } cfg_reg_e;

  // One byte's worth of pixel work handed to the emitter.
  typedef struct packed {
    logic [BYTE_W-1:0]    bits;
    logic [ADDR_BITS-1:0] addr;
    logic [CNT_W-1:0]     count;
    logic                 done;
  } em_load_t;

endpackage

`default_nettype wire

[src/gce_if.sv]
// Request channel interfaces: glyph byte input and pixel write output.
`default_nettype none

interface gce_in_if;
  logic                         valid;
  logic                         ready;
  logic [gce_pkg::BYTE_W-1:0]   glyph_byte;
  logic                         start_glyph;
  logic [gce_pkg::COORD_W-1:0]  origin_x;
  logic [gce_pkg::COORD_W-1:0]  origin_y;

  modport source (output valid, glyph_byte, start_glyph, origin_x, origin_y, input ready);
  modport sink   (input valid, glyph_byte, start_glyph, origin_x, origin_y, output ready);
endinterface

interface gce_out_if;
  logic                           valid;
  logic                           ready;
  logic [gce_pkg::ADDR_BITS-1:0]  pixel_address;
  logic [gce_pkg::COLOR_W-1:0]    pixel_value;
  logic                           last_of_byte;
  logic                           glyph_done;

  modport source (output valid, pixel_address, pixel_value, last_of_byte, glyph_done,
                  input ready);
  modport sink   (input valid, pixel_address, pixel_value, last_of_byte, glyph_done,
                  output ready);
endinterface

`default_nettype wire

[src/gce_pixel_emitter.sv]
// Pixel emitter: walks one loaded byte bit by bit into the output register.
`default_nettype none

module gce_pixel_emitter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load_v,
  input  wire gce_pkg::em_load_t           load,
  output logic                             can_load,
  input  wire logic [gce_pkg::COLOR_W-1:0] fg_color,
  input  wire logic [gce_pkg::COLOR_W-1:0] clear_color,
  gce_out_if.source                        out_ch
);

  logic                              em_v_r, em_v_nxt;
  logic [gce_pkg::BYTE_W-1:0]        em_bits_r, em_bits_nxt;
  logic [gce_pkg::ADDR_BITS-1:0]     em_addr_r, em_addr_nxt;
  logic [gce_pkg::CNT_W-1:0]         em_cnt_r, em_cnt_nxt;
  logic [gce_pkg::IDX_W-1:0]         em_idx_r, em_idx_nxt;
  logic                              em_done_r, em_done_nxt;

  logic                              out_v_r, out_v_nxt;
  logic [gce_pkg::ADDR_BITS-1:0]     out_addr_r, out_addr_nxt;
  logic [gce_pkg::COLOR_W-1:0]       out_val_r, out_val_nxt;
  logic                              out_last_r, out_last_nxt;
  logic                              out_done_r, out_done_nxt;

  logic                              emit;
  logic                              em_last;
  logic [gce_pkg::IDX_W-1:0]         bit_sel;

  assign em_last  = (gce_pkg::CNT_W'(em_idx_r) + 1'b1) == em_cnt_r;
  assign emit     = em_v_r && (!out_v_r || out_ch.ready);
  assign can_load = !em_v_r || (emit && em_last);
  // leftmost pixel sits in the MSB
  assign bit_sel  = gce_pkg::IDX_W'(gce_pkg::BYTE_W - 1) - em_idx_r;

  always_comb begin
    em_v_nxt    = em_v_r;
    em_bits_nxt = em_bits_r;
    em_addr_nxt = em_addr_r;
    em_cnt_nxt  = em_cnt_r;
    em_idx_nxt  = em_idx_r;
    em_done_nxt = em_done_r;

    out_v_nxt    = out_v_r;
    out_addr_nxt = out_addr_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;

    if (emit) begin
      out_v_nxt    = 1'b1;
      out_addr_nxt = em_addr_r + gce_pkg::ADDR_BITS'(em_idx_r);
      out_val_nxt  = em_bits_r[bit_sel] ? fg_color : clear_color;
      out_last_nxt = em_last;
      out_done_nxt = em_done_r && em_last;
      em_idx_nxt   = em_idx_r + 1'b1;
      if (em_last) begin
        em_v_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    if (load_v && can_load) begin
      em_v_nxt    = 1'b1;
      em_bits_nxt = load.bits;
      em_addr_nxt = load.addr;
      em_cnt_nxt  = load.count;
      em_idx_nxt  = '0;
      em_done_nxt = load.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      em_v_r  <= em_v_nxt;
      out_v_r <= out_v_nxt;
    end
    em_bits_r  <= em_bits_nxt;
    em_addr_r  <= em_addr_nxt;
    em_cnt_r   <= em_cnt_nxt;
    em_idx_r   <= em_idx_nxt;
    em_done_r  <= em_done_nxt;
    out_addr_r <= out_addr_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.pixel_value   = out_val_r;
  assign out_ch.last_of_byte  = out_last_r;
  assign out_ch.glyph_done    = out_done_r;

endmodule

`default_nettype wire

[src/glyph_color_expander_core.sv]
// Glyph color expander top level: config registers, glyph walk state, emitter.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | glyph_byte, start_glyph, origin_x, origin_y
//  out_ch  | out | valid/ready   | pixel_address, pixel_value, last_of_byte, glyph_done
//  cfg_*   | in  | cfg_we only   | cfg_index, cfg_wdata
//
// A byte goes input register -> glyph state update -> pixel emitter -> output register.
// The emitter sends one pixel per cycle while out_ch is not stalled, one per drawn column;
// a byte that draws nothing is not loaded into the emitter; the emitter sets the rate.
// An accepted byte passes the input register and the emitter registers before the output
// register raises out_ch.valid. Reset (rst_n low, synchronous) clears all valid flags
// and glyph state and loads the config reset values.
// A stalled out_ch holds the output register; the input stage keeps accepting
// until the input register and the emitter are both full.
`default_nettype none

module glyph_color_expander_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  gce_in_if.sink                                in_ch,
  gce_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [gce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gce_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration
  logic [gce_pkg::COLOR_W-1:0]   fg_color_r;
  logic [gce_pkg::COLOR_W-1:0]   clear_color_r;
  logic [gce_pkg::DIM_W-1:0]     glyph_width_r;
  logic [gce_pkg::DIM_W-1:0]     glyph_height_r;
  logic [gce_pkg::BPR_W-1:0]     bytes_per_row_r;
  logic [gce_pkg::STRIDE_W-1:0]  line_stride_r;
  logic [gce_pkg::FBASE_W-1:0]   frame_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r      <= '1;
      clear_color_r   <= '0;
      glyph_width_r   <= gce_pkg::DIM_W'(8);
      glyph_height_r  <= gce_pkg::DIM_W'(8);
      bytes_per_row_r <= gce_pkg::BPR_W'(1);
      line_stride_r   <= gce_pkg::STRIDE_W'(320);
      frame_base_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gce_pkg::REG_FG_COLOR:      fg_color_r      <= cfg_wdata[gce_pkg::COLOR_W-1:0];
        gce_pkg::REG_CLEAR_COLOR:   clear_color_r   <= cfg_wdata[gce_pkg::COLOR_W-1:0];
        gce_pkg::REG_GLYPH_WIDTH:   glyph_width_r   <= cfg_wdata[gce_pkg::DIM_W-1:0];
        gce_pkg::REG_GLYPH_HEIGHT:  glyph_height_r  <= cfg_wdata[gce_pkg::DIM_W-1:0];
        gce_pkg::REG_BYTES_PER_ROW: bytes_per_row_r <= cfg_wdata[gce_pkg::BPR_W-1:0];
        gce_pkg::REG_LINE_STRIDE:   line_stride_r   <= cfg_wdata[gce_pkg::STRIDE_W-1:0];
        gce_pkg::REG_FRAME_BASE:    frame_base_r    <= cfg_wdata[gce_pkg::FBASE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register; the origin product is formed on the way in
  logic                          s1_v_r, s1_v_nxt;
  logic [gce_pkg::BYTE_W-1:0]    s1_byte_r;
  logic                          s1_start_r;
  logic [gce_pkg::COORD_W-1:0]   s1_ox_r;
  logic [gce_pkg::PROD_W-1:0]    s1_prod_r;
  logic                          s1_take;
  logic                          in_fire;
  logic                          can_load;

  assign s1_take     = s1_v_r && can_load;
  assign in_ch.ready = !s1_v_r || s1_take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_take) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (in_fire) begin
      s1_byte_r  <= in_ch.glyph_byte;
      s1_start_r <= in_ch.start_glyph;
      s1_ox_r    <= in_ch.origin_x;
      s1_prod_r  <= gce_pkg::PROD_W'(in_ch.origin_y) * gce_pkg::PROD_W'(line_stride_r);
    end
  end

  // glyph walk state
  logic [gce_pkg::ADDR_BITS-1:0]  row_addr_r, row_addr_nxt;
  logic [gce_pkg::BIR_W-1:0]      byte_in_row_r, byte_in_row_nxt;
  logic [gce_pkg::DIM_W-1:0]      row_index_r, row_index_nxt;
  logic                           active_r, active_nxt;

  logic [gce_pkg::ADDR_BITS-1:0]  ra_eff;
  logic [gce_pkg::BIR_W-1:0]      bir_cur;
  logic [gce_pkg::DIM_W-1:0]      ri_cur;
  logic                           act_cur;
  logic [gce_pkg::BPR_INT_W-1:0]  bpr;
  logic [gce_pkg::DIM_W-1:0]      height;
  logic [gce_pkg::BIR_W-1:0]      bir_eff;
  logic [gce_pkg::COLS_W-1:0]     cols_cap;
  logic [gce_pkg::DIM_W-1:0]      drawn;
  logic [gce_pkg::DIM_W-1:0]      base_col;
  logic [gce_pkg::DIM_W-1:0]      rem;
  logic                           last_row;
  logic [gce_pkg::BPR_INT_W-1:0]  bir_inc;
  gce_pkg::em_load_t              em_load;
  logic                           em_load_v;

  always_comb begin
    if (s1_start_r) begin
      ra_eff  = gce_pkg::ADDR_BITS'(frame_base_r) + gce_pkg::ADDR_BITS'(s1_prod_r)
              + gce_pkg::ADDR_BITS'(s1_ox_r);
      bir_cur = '0;
      ri_cur  = '0;
      act_cur = 1'b1;
    end else begin
      ra_eff  = row_addr_r;
      bir_cur = byte_in_row_r;
      ri_cur  = row_index_r;
      act_cur = active_r;
    end

    if (bytes_per_row_r == '0) begin
      bpr = gce_pkg::BPR_INT_W'(1);
    end else if (gce_pkg::BPR_INT_W'(bytes_per_row_r) >
                 gce_pkg::BPR_INT_W'(gce_pkg::MAX_GLYPH_BYTES)) begin
      bpr = gce_pkg::BPR_INT_W'(gce_pkg::MAX_GLYPH_BYTES);
    end else begin
      bpr = gce_pkg::BPR_INT_W'(bytes_per_row_r);
    end

    height = (glyph_height_r == '0) ? gce_pkg::DIM_W'(1) : glyph_height_r;

    // bytes per row lowered mid-glyph: stay on the last byte of the row
    bir_eff = (gce_pkg::BPR_INT_W'(bir_cur) >= bpr) ? gce_pkg::BIR_W'(bpr - 1'b1) : bir_cur;

    cols_cap = gce_pkg::COLS_W'({bpr, 3'b000});
    drawn    = (gce_pkg::COLS_W'(glyph_width_r) > cols_cap) ? gce_pkg::DIM_W'(cols_cap)
                                                             : glyph_width_r;
    base_col = gce_pkg::DIM_W'({bir_eff, 3'b000});
    rem      = (drawn > base_col) ? (drawn - base_col) : '0;
    last_row = (gce_pkg::COLS_W'(ri_cur) + 1'b1) >= gce_pkg::COLS_W'(height);

    em_load.bits  = s1_byte_r;
    em_load.addr  = ra_eff + gce_pkg::ADDR_BITS'(base_col);
    em_load.count = (rem > gce_pkg::DIM_W'(8)) ? gce_pkg::CNT_W'(8) : gce_pkg::CNT_W'(rem);
    em_load.done  = last_row && (rem <= gce_pkg::DIM_W'(8));
    em_load_v     = s1_take && act_cur && (rem != '0);

    bir_inc = gce_pkg::BPR_INT_W'(bir_eff) + 1'b1;

    row_addr_nxt    = row_addr_r;
    byte_in_row_nxt = byte_in_row_r;
    row_index_nxt   = row_index_r;
    active_nxt      = active_r;
    if (s1_take && act_cur) begin
      row_addr_nxt    = ra_eff;
      byte_in_row_nxt = gce_pkg::BIR_W'(bir_inc);
      row_index_nxt   = ri_cur;
      active_nxt      = 1'b1;
      if (bir_inc >= bpr) begin
        byte_in_row_nxt = '0;
        row_addr_nxt    = ra_eff + gce_pkg::ADDR_BITS'(line_stride_r);
        row_index_nxt   = ri_cur + 1'b1;
        if (last_row) begin
          active_nxt    = 1'b0;
          row_index_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_addr_r    <= '0;
      byte_in_row_r <= '0;
      row_index_r   <= '0;
      active_r      <= 1'b0;
    end else begin
      row_addr_r    <= row_addr_nxt;
      byte_in_row_r <= byte_in_row_nxt;
      row_index_r   <= row_index_nxt;
      active_r      <= active_nxt;
    end
  end

  gce_pixel_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_v      (em_load_v),
    .load        (em_load),
    .can_load    (can_load),
    .fg_color    (fg_color_r),
    .clear_color (clear_color_r),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

[test/glyph_color_expander_core_test.sv]
// Self-checking testbench for the glyph color expander: directed table, then random glyphs.
`timescale 1ns / 100ps

module glyph_color_expander_core_test;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYC  = 20;

  typedef struct packed {
    logic [gce_pkg::ADDR_BITS-1:0] addr;
    logic [gce_pkg::COLOR_W-1:0]   value;
    logic                          last;
    logic                          done;
  } pixel_t;

  typedef enum logic {ROW_GLYPH, ROW_REG} row_kind_e;

  // Rows with known set carry the expected pixels typed in: kn pixels from kaddr on.
  typedef struct {
    row_kind_e                      kind;
    gce_pkg::cfg_reg_e              reg_id;
    logic [31:0]                    data;
    logic                           start;
    logic [gce_pkg::COORD_W-1:0]    ox;
    logic [gce_pkg::COORD_W-1:0]    oy;
    bit                             known;
    int                             kn;
    logic [gce_pkg::ADDR_BITS-1:0]  kaddr;
    bit                             kdone;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [gce_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gce_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gce_in_if  in_ch();
  gce_out_if out_ch();

  glyph_color_expander_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies, reset values.
  logic [gce_pkg::COLOR_W-1:0]   fg_col  = 32'hFFFF_FFFF;
  logic [gce_pkg::COLOR_W-1:0]   bg_col  = '0;
  logic [gce_pkg::DIM_W-1:0]     gw      = 6'd8;
  logic [gce_pkg::DIM_W-1:0]     gh      = 6'd8;
  logic [gce_pkg::BPR_W-1:0]     bpr_cfg = 3'd1;
  logic [gce_pkg::STRIDE_W-1:0]  stride  = 13'd320;
  logic [gce_pkg::FBASE_W-1:0]   fbase   = '0;

  // Glyph walk state.
  logic [gce_pkg::ADDR_BITS-1:0] walk_addr = '0;
  int unsigned                   walk_byte = 0;
  int unsigned                   walk_row  = 0;
  bit                            walk_live = 1'b0;

  pixel_t    pending_px[$];
  plan_row_t plan[$];
  int        err_cnt   = 0;
  int        idle_cnt  = 0;
  int        gap_pct   = 0;
  int        stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_bpr();
    if (bpr_cfg == 0) return 1;
    if (bpr_cfg > gce_pkg::MAX_GLYPH_BYTES) return gce_pkg::MAX_GLYPH_BYTES;
    return 32'(bpr_cfg);
  endfunction

  function automatic int unsigned eff_height();
    return (gh == 0) ? 1 : 32'(gh);
  endfunction

  function automatic int unsigned glyph_len();
    return eff_bpr() * eff_height();
  endfunction

  // Pixel writes caused by one glyph byte; advances the walk state.
  function automatic void expand_byte(input logic [7:0] bits, input logic start,
                                      input logic [gce_pkg::COORD_W-1:0] ox,
                                      input logic [gce_pkg::COORD_W-1:0] oy,
                                      output int n, output pixel_t px[8], output bit live);
    int unsigned bpr;
    int unsigned cols;
    int unsigned col0;
    int unsigned col;
    bit          last_row;
    n = 0;
    if (start) begin
      walk_addr = gce_pkg::ADDR_BITS'(32'(fbase) + 32'(oy) * 32'(stride) + 32'(ox));
      walk_byte = 0;
      walk_row  = 0;
      walk_live = 1'b1;
    end
    live = walk_live;
    if (!walk_live) return;
    bpr = eff_bpr();
    if (walk_byte >= bpr) walk_byte = bpr - 1;
    cols = (32'(gw) > 8 * bpr) ? 8 * bpr : 32'(gw);
    last_row = (walk_row + 1 >= eff_height());
    col0 = 8 * walk_byte;
    for (int i = 0; i < 8; i++) begin
      col = col0 + i;
      if (col >= cols) break;
      px[n].addr  = walk_addr + gce_pkg::ADDR_BITS'(col);
      px[n].value = bits[7 - i] ? fg_col : bg_col;
      px[n].last  = 1'b0;
      px[n].done  = last_row && (col + 1 == cols);
      n++;
    end
    if (n > 0) px[n - 1].last = 1'b1;
    walk_byte++;
    if (walk_byte >= bpr) begin
      walk_byte = 0;
      walk_addr = walk_addr + gce_pkg::ADDR_BITS'(stride);
      walk_row  = (walk_row + 1) & 6'h3F;
      if (last_row) begin
        walk_live = 1'b0;
        walk_row  = 0;
      end
    end
  endfunction

  function automatic plan_row_t glyph_row(logic [7:0] bits, logic start,
                                          int ox, int oy);
    plan_row_t row;
    row = '{ROW_GLYPH, gce_pkg::REG_FG_COLOR, 32'(bits), start, gce_pkg::COORD_W'(ox),
            gce_pkg::COORD_W'(oy), 1'b0, 0, '0, 1'b0};
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [7:0] bits, logic start, int ox, int oy,
                                          int kn, int kaddr, bit kdone);
    plan_row_t row;
    row = '{ROW_GLYPH, gce_pkg::REG_FG_COLOR, 32'(bits), start, gce_pkg::COORD_W'(ox),
            gce_pkg::COORD_W'(oy), 1'b1, kn, gce_pkg::ADDR_BITS'(kaddr), kdone};
    return row;
  endfunction

  function automatic plan_row_t reg_row(gce_pkg::cfg_reg_e r, logic [31:0] v);
    plan_row_t row;
    row = '{ROW_REG, r, v, 1'b0, '0, '0, 1'b0, 0, '0, 1'b0};
    return row;
  endfunction

  function automatic logic [gce_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return gce_pkg::COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic pace();
    while ($urandom_range(0, 99) < gap_pct) idle_cycle();
  endtask

  // Drop valid, wait for every outstanding pixel, then let trailing empty bytes retire.
  task automatic settle();
    idle_cycle();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(gce_pkg::cfg_reg_e r, logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      gce_pkg::REG_FG_COLOR:      fg_col  = v;
      gce_pkg::REG_CLEAR_COLOR:   bg_col  = v;
      gce_pkg::REG_GLYPH_WIDTH:   gw      = v[gce_pkg::DIM_W-1:0];
      gce_pkg::REG_GLYPH_HEIGHT:  gh      = v[gce_pkg::DIM_W-1:0];
      gce_pkg::REG_BYTES_PER_ROW: bpr_cfg = v[gce_pkg::BPR_W-1:0];
      gce_pkg::REG_LINE_STRIDE:   stride  = v[gce_pkg::STRIDE_W-1:0];
      gce_pkg::REG_FRAME_BASE:    fbase   = v[gce_pkg::FBASE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] bits, input logic start,
                           input logic [gce_pkg::COORD_W-1:0] ox,
                           input logic [gce_pkg::COORD_W-1:0] oy,
                           input bit known, input int kn,
                           input logic [gce_pkg::ADDR_BITS-1:0] kaddr,
                           input bit kdone, output bit live);
    pixel_t px[8];
    pixel_t kp;
    int     n;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.glyph_byte  <= bits;
    in_ch.start_glyph <= start;
    in_ch.origin_x    <= ox;
    in_ch.origin_y    <= oy;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expand_byte(bits, start, ox, oy, n, px, live);
    if (known) begin
      for (int k = 0; k < kn; k++) begin
        kp.addr  = kaddr + gce_pkg::ADDR_BITS'(k);
        kp.value = bits[7 - k] ? fg_col : bg_col;
        kp.last  = (k == kn - 1);
        kp.done  = kdone && (k == kn - 1);
        pending_px.push_back(kp);
      end
    end else begin
      for (int k = 0; k < n; k++) pending_px.push_back(px[k]);
    end
  endtask

  // Receiver back-pressure.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_px.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected pixel: addr %h value %h last %b done %b",
                   out_ch.pixel_address, out_ch.pixel_value,
                   out_ch.last_of_byte, out_ch.glyph_done);
      end else begin
        exp_px = pending_px.pop_front();
        if (out_ch.pixel_address !== exp_px.addr || out_ch.pixel_value !== exp_px.value ||
            out_ch.last_of_byte !== exp_px.last || out_ch.glyph_done !== exp_px.done) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("pixel mismatch: exp addr %h value %h last %b done %b, got %h %h %b %b",
                     exp_px.addr, exp_px.value, exp_px.last, exp_px.done,
                     out_ch.pixel_address, out_ch.pixel_value,
                     out_ch.last_of_byte, out_ch.glyph_done);
        end
      end
    end
  end

  // Watchdog: cycles with no request moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit live;
    bit wrote;
    int live_items;
    int total;
    int r;
    logic start;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = gce_pkg::REG_FG_COLOR;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.glyph_byte  = '0;
    in_ch.start_glyph = 1'b0;
    in_ch.origin_x    = '0;
    in_ch.origin_y    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    plan = '{
      // reset config: 8x8 glyph, one byte per row, stride 320
      known_row(8'hA5, 1'b0, 0, 0, 0, 0, 1'b0),          // nothing active yet
      known_row(8'hFF, 1'b1, 0, 0, 8, 0, 1'b0),
      known_row(8'h00, 1'b0, 0, 0, 8, 320, 1'b0),
      known_row(8'h81, 1'b1, 4095, 4095, 8, 1314495, 1'b0), // restart mid-glyph
      glyph_row(8'h3C, 1'b0, 0, 0),
      glyph_row(8'h42, 1'b0, 0, 0),
      glyph_row(8'h99, 1'b0, 0, 0),
      glyph_row(8'hE7, 1'b0, 0, 0),
      glyph_row(8'h18, 1'b0, 0, 0),
      glyph_row(8'h5A, 1'b0, 0, 0),
      known_row(8'hC3, 1'b0, 0, 0, 8, 1316735, 1'b1),
      // address wrap with maximum origin and stride
      reg_row(gce_pkg::REG_FRAME_BASE, 32'h00FF_FFFF),
      reg_row(gce_pkg::REG_LINE_STRIDE, 32'd8191),
      reg_row(gce_pkg::REG_FG_COLOR, 32'h0),
      reg_row(gce_pkg::REG_CLEAR_COLOR, 32'hFFFF_FFFF),
      glyph_row(8'hF0, 1'b1, 4095, 4095),
      // zero width draws nothing
      reg_row(gce_pkg::REG_GLYPH_WIDTH, 32'd0),
      glyph_row(8'hFF, 1'b1, 17, 3),
      // widest legal glyph row, single row
      reg_row(gce_pkg::REG_GLYPH_WIDTH, 32'd32),
      reg_row(gce_pkg::REG_BYTES_PER_ROW, 32'd4),
      reg_row(gce_pkg::REG_GLYPH_HEIGHT, 32'd1),
      reg_row(gce_pkg::REG_LINE_STRIDE, 32'd1),
      reg_row(gce_pkg::REG_FRAME_BASE, 32'h0),
      glyph_row(8'h80, 1'b1, 0, 4095),
      glyph_row(8'h01, 1'b0, 0, 0),
      glyph_row(8'h7E, 1'b0, 0, 0),
      glyph_row(8'hC3, 1'b0, 0, 0),
      // bytes per row saturates, width clipped to the bytes, zero height acts as one
      reg_row(gce_pkg::REG_BYTES_PER_ROW, 32'd7),
      reg_row(gce_pkg::REG_GLYPH_WIDTH, 32'd63),
      reg_row(gce_pkg::REG_GLYPH_HEIGHT, 32'd0),
      glyph_row(8'hAA, 1'b1, 2048, 1),
      glyph_row(8'h55, 1'b0, 0, 0),
      glyph_row(8'h0F, 1'b0, 0, 0),
      glyph_row(8'hFF, 1'b0, 0, 0),
      // zero bytes per row acts as one
      reg_row(gce_pkg::REG_BYTES_PER_ROW, 32'd0),
      reg_row(gce_pkg::REG_GLYPH_WIDTH, 32'd5),
      glyph_row(8'hF8, 1'b1, 100, 2),
      // padding byte draws nothing but still counts
      reg_row(gce_pkg::REG_BYTES_PER_ROW, 32'd2),
      reg_row(gce_pkg::REG_GLYPH_HEIGHT, 32'd2),
      glyph_row(8'hFF, 1'b1, 7, 9),
      glyph_row(8'hFF, 1'b0, 0, 0),
      glyph_row(8'h00, 1'b0, 0, 0),
      glyph_row(8'hAA, 1'b0, 0, 0)
    };

    wrote = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!wrote) settle();
        write_reg(plan[i].reg_id, plan[i].data);
        wrote = 1'b1;
      end else begin
        send_byte(plan[i].data[7:0], plan[i].start, plan[i].ox, plan[i].oy, plan[i].known,
                  plan[i].kn, plan[i].kaddr, plan[i].kdone, live);
        wrote = 1'b0;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      write_reg(gce_pkg::REG_FG_COLOR, $urandom);
      write_reg(gce_pkg::REG_CLEAR_COLOR, $urandom);
      if (p == 1) begin
        write_reg(gce_pkg::REG_GLYPH_WIDTH, 32'd32);
        write_reg(gce_pkg::REG_GLYPH_HEIGHT, 32'd32);
        write_reg(gce_pkg::REG_BYTES_PER_ROW, 32'd4);
        write_reg(gce_pkg::REG_LINE_STRIDE, 32'd4096);
        write_reg(gce_pkg::REG_FRAME_BASE, 32'h00FF_FFFF);
      end else if (p == 2) begin
        write_reg(gce_pkg::REG_GLYPH_WIDTH, 32'd1);
        write_reg(gce_pkg::REG_GLYPH_HEIGHT, 32'd1);
        write_reg(gce_pkg::REG_BYTES_PER_ROW, 32'd1);
        write_reg(gce_pkg::REG_LINE_STRIDE, 32'd1);
        write_reg(gce_pkg::REG_FRAME_BASE, 32'h0);
      end else begin
        write_reg(gce_pkg::REG_GLYPH_WIDTH,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 16));
        write_reg(gce_pkg::REG_GLYPH_HEIGHT,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6));
        write_reg(gce_pkg::REG_BYTES_PER_ROW, $urandom_range(0, 7));
        write_reg(gce_pkg::REG_LINE_STRIDE, $urandom_range(0, 8191));
        write_reg(gce_pkg::REG_FRAME_BASE, $urandom);
      end

      live_items = 0;
      while (live_items < PHASE_ITEMS) begin
        // mostly whole glyphs, some cut short, some stray bytes
        r = $urandom_range(0, 99);
        if (r < 80)
          total = glyph_len();
        else if (r < 90)
          total = (glyph_len() > 1) ? $urandom_range(1, glyph_len() - 1) : 1;
        else
          total = 1;
        for (int k = 0; k < total; k++) begin
          pace();
          start = (k == 0) && (r < 90 || $urandom_range(0, 3) == 0);
          send_byte(8'($urandom_range(0, 255)), start, pick_coord(), pick_coord(),
                    1'b0, 0, '0, 1'b0, live);
          if (live) live_items++;
        end
      end
    end

    idle_cycle();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0 && pending_px.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
